/* rtl/core/v3n_pkg.sv */
// Shared constants for the three-axis vector normaliser.
`default_nettype none
package v3n_pkg;
  localparam int SAMPLE_WIDTH_DEF = 16;  // default sample width
  localparam int IN_W             = 16;  // width of an input component port
  localparam int UNIT_W           = 16;  // width of a normalised component
  localparam int MAG_W            = 24;  // width of the magnitude port
  localparam int FRAC_SHIFT       = 22;  // numerator scaling: Q1.14 times 8 magnitude bits
  localparam int MAG_FRAC         = 8;   // fraction bits of the magnitude
  localparam int QW               = 15;  // quotient bits: the quotient never exceeds 2^14
  localparam int UNIT_ONE         = 16384;
  localparam int LANES            = 3;
endpackage
`default_nettype wire

/* rtl/core/v3n_sqrt_cell.sv */
// One cell of the square-root chain: settles one bit of the root per beat.
`default_nettype none
module v3n_sqrt_cell #(
  parameter int RAD_W  = 48,
  parameter int ROOT_W = 24,
  parameter int SIDE_W = 52,
  parameter int BIT_I  = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  input  wire logic [RAD_W-1:0]  up_rem,
  input  wire logic [ROOT_W-1:0] up_root,
  input  wire logic [SIDE_W-1:0] up_side,
  output logic                   up_ready,
  output logic                   dn_valid,
  output logic [RAD_W-1:0]       dn_rem,
  output logic [ROOT_W-1:0]      dn_root,
  output logic [SIDE_W-1:0]      dn_side,
  input  wire logic              dn_ready
);
  logic              valid_r;
  logic [RAD_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [RAD_W:0]    trial;
  logic              take;

  // trial subtrahend (2*root + 2^i) * 2^i; root holds only bits above i
  always_comb begin
    trial    = ((RAD_W+1)'(up_root) << (BIT_I + 1)) | ((RAD_W+1)'(1) << (2 * BIT_I));
    take     = {1'b0, up_rem} >= trial;
    rem_nxt  = take ? RAD_W'({1'b0, up_rem} - trial) : up_rem;
    root_nxt = take ? (up_root | (ROOT_W'(1) << BIT_I)) : up_root;
  end

  assign up_ready = !valid_r || dn_ready;

  // hold while the neighbour stalls, otherwise advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= up_side;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem   = rem_r;
  assign dn_root  = root_r;
  assign dn_side  = side_r;
endmodule
`default_nettype wire

/* rtl/core/v3n_div_cell.sv */
// One cell of the division chain: settles one quotient bit of each lane per beat.
`default_nettype none
module v3n_div_cell #(
  parameter int NUM_W  = 38,
  parameter int DEN_W  = 24,
  parameter int SIDE_W = 4,
  parameter int BIT_I  = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  input  wire logic [NUM_W-1:0]     up_rem  [v3n_pkg::LANES],
  input  wire logic [v3n_pkg::QW-1:0] up_quo [v3n_pkg::LANES],
  input  wire logic [DEN_W-1:0]     up_den,
  input  wire logic [SIDE_W-1:0]    up_side,
  output logic                      up_ready,
  output logic                      dn_valid,
  output logic [NUM_W-1:0]          dn_rem  [v3n_pkg::LANES],
  output logic [v3n_pkg::QW-1:0]    dn_quo  [v3n_pkg::LANES],
  output logic [DEN_W-1:0]          dn_den,
  output logic [SIDE_W-1:0]         dn_side,
  input  wire logic                 dn_ready
);
  logic                   valid_r;
  logic [NUM_W-1:0]       rem_r   [v3n_pkg::LANES];
  logic [NUM_W-1:0]       rem_nxt [v3n_pkg::LANES];
  logic [v3n_pkg::QW-1:0] quo_r   [v3n_pkg::LANES];
  logic [v3n_pkg::QW-1:0] quo_nxt [v3n_pkg::LANES];
  logic [DEN_W-1:0]       den_r;
  logic [SIDE_W-1:0]      side_r;
  logic [NUM_W-1:0]       shifted;

  // compare and subtract the shifted divisor in every lane
  always_comb begin
    shifted = NUM_W'(up_den) << BIT_I;
    for (int l = 0; l < v3n_pkg::LANES; l++) begin
      if (up_rem[l] >= shifted) begin
        rem_nxt[l] = up_rem[l] - shifted;
        quo_nxt[l] = up_quo[l] | (v3n_pkg::QW'(1) << BIT_I);
      end else begin
        rem_nxt[l] = up_rem[l];
        quo_nxt[l] = up_quo[l];
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      den_r  <= up_den;
      side_r <= up_side;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem   = rem_r;
  assign dn_quo   = quo_r;
  assign dn_den   = den_r;
  assign dn_side  = side_r;
endmodule
`default_nettype wire

/* rtl/core/vector3_normalizer_unit.sv */
// Top level of the three-axis vector normaliser: front stages, root and divide chains.
// Takes one vector per clock while in_stall is low and returns its length (8 fraction bits)
// and the three Q1.14 unit components. From an accepted input beat to the output register
// a beat passes three front stages for magnitude, squares and their sum, one square-root
// cell per root bit (SAMPLE_WIDTH + 8), fifteen divider cells shared by the three
// components, and the output register, the first front stage being loaded at the
// accepting edge. Every cell holds its beat independently, so bubbles close up behind a
// stalled output and input beats keep flowing until the chain is full. An all-zero vector
// returns zero components with zero_vector set.
`default_nettype none
module vector3_normalizer_unit #(
  parameter int SAMPLE_WIDTH = v3n_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [v3n_pkg::IN_W-1:0]    in_x_in,
  input  wire logic signed [v3n_pkg::IN_W-1:0]    in_y_in,
  input  wire logic signed [v3n_pkg::IN_W-1:0]    in_z_in,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [v3n_pkg::UNIT_W-1:0]       out_x_unit,
  output logic signed [v3n_pkg::UNIT_W-1:0]       out_y_unit,
  output logic signed [v3n_pkg::UNIT_W-1:0]       out_z_unit,
  output logic [v3n_pkg::MAG_W-1:0]               out_magnitude,
  output logic                                    out_zero_vector
);
  localparam int SW     = SAMPLE_WIDTH;
  localparam int RAD_W  = 2 * SW + 2 * v3n_pkg::MAG_FRAC;
  localparam int ROOT_W = SW + v3n_pkg::MAG_FRAC;
  localparam int NUM_W  = SW + v3n_pkg::FRAC_SHIFT;
  localparam int SQ_SIDE_W = 1 + v3n_pkg::LANES + v3n_pkg::LANES * SW;
  localparam int DV_SIDE_W = 1 + v3n_pkg::LANES;
  localparam int L = v3n_pkg::LANES;

  // ---------------- front stages ----------------
  logic [v3n_pkg::IN_W-1:0] raw [L];
  logic [SW-1:0] trunc_v [L];
  logic [SW-1:0] abs_nxt [L];
  logic [SW-1:0] abs_r   [L];
  logic [L-1:0]  sgn_nxt, sgn_a_r, sgn_b_r, sgn_c_r;
  logic [2*SW-1:0] sq_r  [L];
  logic [SW-1:0]   abs_b_r [L];
  logic [SW-1:0]   abs_c_r [L];
  logic [2*SW+1:0] sum_r;
  logic v_a_r, v_b_r, v_c_r;
  logic adv_a, adv_b, adv_c;

  assign raw[0] = in_x_in;
  assign raw[1] = in_y_in;
  assign raw[2] = in_z_in;

  // take the low sample bits, zero-extend and fold to magnitude
  always_comb begin
    for (int l = 0; l < L; l++) begin
      trunc_v[l] = SW'(32'(raw[l]));
      sgn_nxt[l] = trunc_v[l][SW-1];
      abs_nxt[l] = sgn_nxt[l] ? (~trunc_v[l] + SW'(1)) : trunc_v[l];
    end
  end

  logic sq_rdy0;
  assign adv_c    = !v_c_r || sq_rdy0;
  assign adv_b    = !v_b_r || adv_c;
  assign adv_a    = !v_a_r || adv_b;
  assign in_stall = !adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else begin
      if (adv_a) v_a_r <= in_valid;
      if (adv_b) v_b_r <= v_a_r;
      if (adv_c) v_c_r <= v_b_r;
    end
  end

  // absolute values, then squares, then their sum
  always_ff @(posedge clk) begin
    if (adv_a) begin
      abs_r   <= abs_nxt;
      sgn_a_r <= sgn_nxt;
    end
    if (adv_b) begin
      for (int l = 0; l < L; l++) sq_r[l] <= abs_r[l] * abs_r[l];
      abs_b_r <= abs_r;
      sgn_b_r <= sgn_a_r;
    end
    if (adv_c) begin
      sum_r   <= (2*SW+2)'(sq_r[0]) + (2*SW+2)'(sq_r[1]) + (2*SW+2)'(sq_r[2]);
      abs_c_r <= abs_b_r;
      sgn_c_r <= sgn_b_r;
    end
  end

  // ---------------- square-root chain ----------------
  logic                 sq_v    [ROOT_W+1];
  logic                 sq_rdy  [ROOT_W+1];
  logic [RAD_W-1:0]     sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]    sq_root [ROOT_W+1];
  logic [SQ_SIDE_W-1:0] sq_side [ROOT_W+1];

  assign sq_v[0]    = v_c_r;
  assign sq_rem[0]  = RAD_W'({sum_r, (2 * v3n_pkg::MAG_FRAC)'(0)});
  assign sq_root[0] = '0;
  assign sq_side[0] = {sum_r == '0, sgn_c_r, abs_c_r[0], abs_c_r[1], abs_c_r[2]};
  assign sq_rdy0    = sq_rdy[0];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    v3n_sqrt_cell #(
      .RAD_W(RAD_W), .ROOT_W(ROOT_W), .SIDE_W(SQ_SIDE_W), .BIT_I(ROOT_W - 1 - k)
    ) u_cell (
      .clk(clk), .rst_n(rst_n),
      .up_valid(sq_v[k]), .up_rem(sq_rem[k]), .up_root(sq_root[k]),
      .up_side(sq_side[k]), .up_ready(sq_rdy[k]),
      .dn_valid(sq_v[k+1]), .dn_rem(sq_rem[k+1]), .dn_root(sq_root[k+1]),
      .dn_side(sq_side[k+1]), .dn_ready(sq_rdy[k+1])
    );
  end

  // ---------------- division chain ----------------
  localparam int DN = v3n_pkg::QW;
  logic                   dv_v    [DN+1];
  logic                   dv_rdy  [DN+1];
  logic [NUM_W-1:0]       dv_rem  [DN+1][L];
  logic [v3n_pkg::QW-1:0] dv_quo  [DN+1][L];
  logic [ROOT_W-1:0]      dv_den  [DN+1];
  logic [DV_SIDE_W-1:0]   dv_side [DN+1];
  logic [SW-1:0]          sq_abs  [L];

  assign sq_abs[0] = sq_side[ROOT_W][3*SW-1:2*SW];
  assign sq_abs[1] = sq_side[ROOT_W][2*SW-1:SW];
  assign sq_abs[2] = sq_side[ROOT_W][SW-1:0];

  assign dv_v[0]       = sq_v[ROOT_W];
  assign sq_rdy[ROOT_W] = dv_rdy[0];
  assign dv_den[0]     = sq_root[ROOT_W];
  assign dv_side[0]    = sq_side[ROOT_W][SQ_SIDE_W-1 -: DV_SIDE_W];
  for (genvar l = 0; l < L; l++) begin : g_num
    assign dv_rem[0][l] = {sq_abs[l], v3n_pkg::FRAC_SHIFT'(0)};
    assign dv_quo[0][l] = '0;
  end

  for (genvar k = 0; k < DN; k++) begin : g_div
    v3n_div_cell #(
      .NUM_W(NUM_W), .DEN_W(ROOT_W), .SIDE_W(DV_SIDE_W), .BIT_I(DN - 1 - k)
    ) u_cell (
      .clk(clk), .rst_n(rst_n),
      .up_valid(dv_v[k]), .up_rem(dv_rem[k]), .up_quo(dv_quo[k]),
      .up_den(dv_den[k]), .up_side(dv_side[k]), .up_ready(dv_rdy[k]),
      .dn_valid(dv_v[k+1]), .dn_rem(dv_rem[k+1]), .dn_quo(dv_quo[k+1]),
      .dn_den(dv_den[k+1]), .dn_side(dv_side[k+1]), .dn_ready(dv_rdy[k+1])
    );
  end

  // ---------------- output register ----------------
  logic out_valid_r, out_adv, zero_f;
  logic [L-1:0] sgn_f;
  logic [v3n_pkg::QW-1:0] qs;
  logic [v3n_pkg::UNIT_W-1:0] unit_nxt [L];
  logic [v3n_pkg::UNIT_W-1:0] unit_r   [L];
  logic [v3n_pkg::MAG_W-1:0]  mag_r;
  logic zero_r;

  assign out_adv        = !out_valid_r || !out_stall;
  assign dv_rdy[DN]     = out_adv;
  assign zero_f         = dv_side[DN][DV_SIDE_W-1];
  assign sgn_f          = dv_side[DN][L-1:0];

  // clamp, restore sign, force zero for the null vector
  always_comb begin
    qs = '0;
    for (int l = 0; l < L; l++) begin
      qs = (dv_quo[DN][l] > v3n_pkg::QW'(v3n_pkg::UNIT_ONE)) ?
           v3n_pkg::QW'(v3n_pkg::UNIT_ONE) : dv_quo[DN][l];
      unit_nxt[l] = sgn_f[l] ? (~{1'b0, qs} + v3n_pkg::UNIT_W'(1)) : {1'b0, qs};
      if (zero_f) unit_nxt[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= dv_v[DN];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      unit_r <= unit_nxt;
      mag_r  <= v3n_pkg::MAG_W'(dv_den[DN]);
      zero_r <= zero_f;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_unit      = unit_r[0];
  assign out_y_unit      = unit_r[1];
  assign out_z_unit      = unit_r[2];
  assign out_magnitude   = mag_r;
  assign out_zero_vector = zero_r;
endmodule
`default_nettype wire

/* rtl/core/v3n_checker.sv */
// Port-level checks for the vector normaliser, bound to the top level.
`default_nettype none
module v3n_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [v3n_pkg::UNIT_W-1:0] out_x_unit,
  input wire logic signed [v3n_pkg::UNIT_W-1:0] out_y_unit,
  input wire logic signed [v3n_pkg::UNIT_W-1:0] out_z_unit,
  input wire logic [v3n_pkg::MAG_W-1:0]     out_magnitude,
  input wire logic                          out_zero_vector
);
  // a stalled result beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its magnitude, x component and zero flag
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_magnitude) && $stable(out_x_unit)
      && $stable(out_zero_vector))
    else $error("result payload changed while stalled");

  // a null vector gives all-zero fields
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_vector |-> out_magnitude == '0 && out_x_unit == '0
      && out_y_unit == '0 && out_z_unit == '0)
    else $error("null vector with non-zero fields");

  // components stay within unit range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_x_unit <= 16'sd16384 && out_x_unit >= -16'sd16384
      && out_y_unit <= 16'sd16384 && out_y_unit >= -16'sd16384
      && out_z_unit <= 16'sd16384 && out_z_unit >= -16'sd16384)
    else $error("unit component out of range");
endmodule

bind vector3_normalizer_unit v3n_checker u_v3n_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_x_unit(out_x_unit), .out_y_unit(out_y_unit), .out_z_unit(out_z_unit),
  .out_magnitude(out_magnitude), .out_zero_vector(out_zero_vector)
);
`default_nettype wire
